### rtl/phr_pkg.sv
// shared constants, types and state codes for the photon histogram with rebin
// no dependencies
`default_nettype none

package phr_pkg;

    // image geometry
    localparam int X_SIZE      = 256;
    localparam int Y_SIZE      = 256;
    localparam int MAX_FACTOR  = 16;

    // field and register widths
    localparam int COORD_W     = 8;
    localparam int LIM_W       = 9;
    localparam int FAC_W       = 5;
    localparam int CNT_W       = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 9;

    // store sizes
    localparam int FULL_DEPTH  = X_SIZE * Y_SIZE;
    localparam int FULL_AW     = $clog2(FULL_DEPTH);
    localparam int REBIN_DEPTH = (X_SIZE / 2) * (Y_SIZE / 2);
    localparam int REBIN_AW    = $clog2(REBIN_DEPTH);

    // divider sizes
    localparam int DIVD_W      = LIM_W;
    localparam int DIVS_W      = FAC_W;
    localparam int STEP_W      = $clog2(DIVD_W + 1);
    localparam int RIDX_W      = 2 * DIVD_W + 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_X_LIMIT      = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_Y_LIMIT      = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_REBIN_FACTOR = CFG_IDX_W'(2);

    // item function codes
    localparam logic FUNC_EVENT = 1'b0;
    localparam logic FUNC_CLEAR = 1'b1;

    // control of the shared divider lanes
    typedef struct packed {
        logic load;
        logic step;
    } t_div_ctrl;

    // sequencer states
    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_DIV   = 7'b0000100,
        S_INDEX = 7'b0001000,
        S_READ  = 7'b0010000,
        S_WRITE = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

endpackage

`default_nettype wire

### rtl/phr_div.sv
// bit-serial restoring divider, one quotient bit per step
// depends on phr_pkg
`default_nettype none

module phr_div
    import phr_pkg::*;
(
    input  wire logic              i_clk,
    input  wire t_div_ctrl         i_ctrl,
    input  wire logic [DIVD_W-1:0] i_dividend,
    input  wire logic [DIVS_W-1:0] i_divisor,
    output logic      [DIVD_W-1:0] o_quotient
);

    logic [DIVS_W-1:0] r_rem;
    logic [DIVS_W-1:0] r_dsr;
    logic [DIVD_W-1:0] r_dvd;
    logic [DIVS_W:0]   w_trial;
    logic              w_qbit;
    logic [DIVS_W:0]   w_diff;

    // trial subtract of the divisor from the shifted remainder
    always_comb begin
        w_trial = {r_rem, r_dvd[DIVD_W-1]};
        w_qbit  = (w_trial >= {1'b0, r_dsr});
        w_diff  = w_trial - {1'b0, r_dsr};
    end

    // dividend shifts out at the top while quotient bits shift in at the bottom
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_rem <= '0;
            r_dsr <= i_divisor;
            r_dvd <= i_dividend;
        end else if (i_ctrl.step) begin
            r_rem <= w_qbit ? w_diff[DIVS_W-1:0] : w_trial[DIVS_W-1:0];
            r_dvd <= {r_dvd[DIVD_W-2:0], w_qbit};
        end
    end

    assign o_quotient = r_dvd;

endmodule

`default_nettype wire

### rtl/photon_histogram_with_rebin.sv
// photon histogram top level: count image, rebinned image, peaks and sequencer
// depends on phr_pkg and phr_div
//
// usage
//   input channel (i_in_valid / o_in_ready) takes one item: i_func selects a
//   photon event at (i_x_coord, i_y_coord) or a clear of both images and peaks.
//   output channel (o_out_valid / i_out_ready) returns one result per item.
//   config channel (i_cfg_valid / o_cfg_ready), always ready, writes by index
//   x_limit, y_limit, rebin_factor; user writes only while idle, not enforced.
// operation
//   an in-range event first runs the serial dividers that form the rebinned
//   coordinates and rebinned image size, then index, memory read and write back.
//   a rejected event skips the dividers and memories and goes straight to its result.
//   a clear walks all 65536 count image addresses, one per cycle, zeroing the
//   rebinned image alongside, and gives its result after the walk.
//   one item is in flight at a time; the next is taken once the previous one
//   sits in the output register.
// reset
//   reset loads the default registers and starts the same clearing walk over
//   all 65536 addresses; no item is taken until it is done.
// stall
//   a held result stays in the output register; one more item may be worked
//   on and then waits for the output register to free up.
`default_nettype none

module photon_histogram_with_rebin
    import phr_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // input items
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic                  i_func,
    input  wire logic [COORD_W-1:0]    i_x_coord,
    input  wire logic [COORD_W-1:0]    i_y_coord,
    // results
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic                       o_accepted,
    output logic [CNT_W-1:0]           o_bin_count,
    output logic [CNT_W-1:0]           o_peak_count,
    output logic [CNT_W-1:0]           o_rebin_count,
    output logic [CNT_W-1:0]           o_rebin_peak,
    // configuration writes
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == '1) ? v : v + CNT_W'(1);
    endfunction

    t_state r_state, n_state;

    // configuration registers
    logic [LIM_W-1:0] r_x_limit;
    logic [LIM_W-1:0] r_y_limit;
    logic [FAC_W-1:0] r_rebin_factor;

    // item working registers
    logic               r_rebin_on;
    logic [FULL_AW-1:0] r_full_idx;
    logic [REBIN_AW-1:0] r_rb_idx;
    logic               r_rb_ok;
    logic [STEP_W-1:0]  r_step;
    logic [FULL_AW-1:0] r_clr_addr;
    logic               r_clr_item;

    // peaks and pending result
    logic [CNT_W-1:0] r_peak;
    logic [CNT_W-1:0] r_rb_peak;
    logic             r_res_acc;
    logic [CNT_W-1:0] r_res_bin;
    logic [CNT_W-1:0] r_res_rbin;

    // output register
    logic             r_out_valid;
    logic             r_o_acc;
    logic [CNT_W-1:0] r_o_bin;
    logic [CNT_W-1:0] r_o_peak;
    logic [CNT_W-1:0] r_o_rbin;
    logic [CNT_W-1:0] r_o_rb_peak;

    // memories
    logic [CNT_W-1:0] r_full_mem [FULL_DEPTH];
    logic [CNT_W-1:0] r_rb_mem   [REBIN_DEPTH];
    logic [CNT_W-1:0] r_full_rd;
    logic [CNT_W-1:0] r_rb_rd;

    logic                w_full_we;
    logic [FULL_AW-1:0]  w_full_waddr;
    logic [CNT_W-1:0]    w_full_wdata;
    logic                w_rb_we;
    logic [REBIN_AW-1:0] w_rb_waddr;
    logic [CNT_W-1:0]    w_rb_wdata;

    // combinational helpers
    logic             w_in_xfer;
    logic             w_out_load;
    logic [LIM_W-1:0] w_xl;
    logic [LIM_W-1:0] w_yl;
    logic [FAC_W-1:0] w_fac;
    logic             w_in_range;
    logic             w_clr_last;
    logic             w_step_last;
    t_div_ctrl        w_div_ctrl;
    logic [DIVD_W-1:0] w_bx, w_by, w_rx, w_ry;
    logic [RIDX_W-1:0] w_ridx;
    logic [CNT_W-1:0] w_bin;
    logic [CNT_W-1:0] w_rbin;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_xfer   = i_in_valid && o_in_ready;
    assign w_out_load  = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
    assign w_clr_last  = (r_clr_addr == FULL_AW'(FULL_DEPTH - 1));
    assign w_step_last = (r_step == STEP_W'(DIVD_W - 1));

    // effective limits and factor
    always_comb begin
        w_xl = (32'(r_x_limit) < X_SIZE) ? r_x_limit : LIM_W'(X_SIZE);
        w_yl = (32'(r_y_limit) < Y_SIZE) ? r_y_limit : LIM_W'(Y_SIZE);
        if (r_rebin_factor == '0) begin
            w_fac = FAC_W'(1);
        end else if (32'(r_rebin_factor) > MAX_FACTOR) begin
            w_fac = FAC_W'(MAX_FACTOR);
        end else begin
            w_fac = r_rebin_factor;
        end
        w_in_range = (LIM_W'(i_x_coord) < w_xl) && (LIM_W'(i_y_coord) < w_yl);
    end

    // divider lanes: x/f, y/f, x limit/f, y limit/f
    assign w_div_ctrl.load = w_in_xfer;
    assign w_div_ctrl.step = (r_state == S_DIV);

    phr_div u_div_bx (
        .i_clk      (i_clk),
        .i_ctrl     (w_div_ctrl),
        .i_dividend (DIVD_W'(i_x_coord)),
        .i_divisor  (w_fac),
        .o_quotient (w_bx)
    );

    phr_div u_div_by (
        .i_clk      (i_clk),
        .i_ctrl     (w_div_ctrl),
        .i_dividend (DIVD_W'(i_y_coord)),
        .i_divisor  (w_fac),
        .o_quotient (w_by)
    );

    phr_div u_div_rx (
        .i_clk      (i_clk),
        .i_ctrl     (w_div_ctrl),
        .i_dividend (w_xl),
        .i_divisor  (w_fac),
        .o_quotient (w_rx)
    );

    phr_div u_div_ry (
        .i_clk      (i_clk),
        .i_ctrl     (w_div_ctrl),
        .i_dividend (w_yl),
        .i_divisor  (w_fac),
        .o_quotient (w_ry)
    );

    // rebinned bin index, column major with the rebinned height
    assign w_ridx = RIDX_W'(w_bx) * RIDX_W'(w_ry) + RIDX_W'(w_by);

    // incremented counts from the read data
    assign w_bin  = sat_inc(r_full_rd);
    assign w_rbin = r_rb_ok ? sat_inc(r_rb_rd) : '0;

    // memory write port selection: clearing walk or write back
    always_comb begin
        w_full_we    = 1'b0;
        w_full_waddr = r_full_idx;
        w_full_wdata = w_bin;
        w_rb_we      = 1'b0;
        w_rb_waddr   = r_rb_idx;
        w_rb_wdata   = w_rbin;
        case (r_state)
            S_CLEAR: begin
                w_full_we    = 1'b1;
                w_full_waddr = r_clr_addr;
                w_full_wdata = '0;
                w_rb_we      = (32'(r_clr_addr) < REBIN_DEPTH);
                w_rb_waddr   = r_clr_addr[REBIN_AW-1:0];
                w_rb_wdata   = '0;
            end
            S_WRITE: begin
                w_full_we = 1'b1;
                w_rb_we   = r_rb_ok;
            end
            default: begin
            end
        endcase
    end

    // count image memory
    always_ff @(posedge i_clk) begin
        if (w_full_we) begin
            r_full_mem[w_full_waddr] <= w_full_wdata;
        end
        r_full_rd <= r_full_mem[r_full_idx];
    end

    // rebinned image memory
    always_ff @(posedge i_clk) begin
        if (w_rb_we) begin
            r_rb_mem[w_rb_waddr] <= w_rb_wdata;
        end
        r_rb_rd <= r_rb_mem[r_rb_idx];
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (w_clr_last) begin
                    n_state = r_clr_item ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_in_xfer) begin
                    if (i_func == FUNC_CLEAR) begin
                        n_state = S_CLEAR;
                    end else if (w_in_range) begin
                        n_state = S_DIV;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DIV: begin
                if (w_step_last) begin
                    n_state = S_INDEX;
                end
            end
            S_INDEX: n_state = S_READ;
            S_READ:  n_state = S_WRITE;
            S_WRITE: n_state = S_DONE;
            S_DONE: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control state, configuration and peaks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLEAR;
            r_clr_addr     <= '0;
            r_clr_item     <= 1'b0;
            r_step         <= '0;
            r_x_limit      <= LIM_W'(256);
            r_y_limit      <= LIM_W'(256);
            r_rebin_factor <= FAC_W'(1);
            r_peak         <= '0;
            r_rb_peak      <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;

            // configuration transfer
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_X_LIMIT:      r_x_limit      <= i_cfg_data[LIM_W-1:0];
                    REG_Y_LIMIT:      r_y_limit      <= i_cfg_data[LIM_W-1:0];
                    REG_REBIN_FACTOR: r_rebin_factor <= i_cfg_data[FAC_W-1:0];
                    default: begin
                    end
                endcase
            end

            // clearing walk address
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + FULL_AW'(1);
            end

            // clear item starts a walk and zeroes the peaks
            if (w_in_xfer && (i_func == FUNC_CLEAR)) begin
                r_clr_addr <= '0;
                r_clr_item <= 1'b1;
                r_peak     <= '0;
                r_rb_peak  <= '0;
            end

            // divider step count
            if (w_in_xfer) begin
                r_step <= '0;
            end else if (r_state == S_DIV) begin
                r_step <= r_step + STEP_W'(1);
            end

            // peak tracking at write back
            if (r_state == S_WRITE) begin
                if (w_bin > r_peak) begin
                    r_peak <= w_bin;
                end
                if (r_rb_ok && (w_rbin > r_rb_peak)) begin
                    r_rb_peak <= w_rbin;
                end
            end

            // output register valid
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_full_idx <= FULL_AW'(FULL_AW'(i_x_coord) * FULL_AW'(Y_SIZE))
                          + FULL_AW'(i_y_coord);
            r_rebin_on <= (w_fac > FAC_W'(1));
            r_res_acc  <= 1'b0;
            r_res_bin  <= '0;
            r_res_rbin <= '0;
        end
        if (r_state == S_INDEX) begin
            r_rb_idx <= w_ridx[REBIN_AW-1:0];
            r_rb_ok  <= r_rebin_on && (w_bx < w_rx) && (w_by < w_ry)
                        && (32'(w_ridx) < REBIN_DEPTH);
        end
        if (r_state == S_WRITE) begin
            r_res_acc  <= 1'b1;
            r_res_bin  <= w_bin;
            r_res_rbin <= w_rbin;
        end
    end

    // output register load
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_o_acc     <= r_res_acc;
            r_o_bin     <= r_res_bin;
            r_o_peak    <= r_peak;
            r_o_rbin    <= r_res_rbin;
            r_o_rb_peak <= r_rb_peak;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_accepted    = r_o_acc;
    assign o_bin_count   = r_o_bin;
    assign o_peak_count  = r_o_peak;
    assign o_rebin_count = r_o_rbin;
    assign o_rebin_peak  = r_o_rb_peak;

endmodule

`default_nettype wire

### sim/histogram_checker.sv
// checker for the photon histogram: watches the input, result and config channels,
// keeps its own copy of both count images and peaks, and compares every result
// depends on phr_pkg
`timescale 1ns / 1ps

module histogram_checker
    import phr_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // input channel
    input  wire logic                  i_in_valid,
    input  wire logic                  i_in_ready,
    input  wire logic                  i_func,
    input  wire logic [COORD_W-1:0]    i_x_coord,
    input  wire logic [COORD_W-1:0]    i_y_coord,
    // result channel
    input  wire logic                  i_out_valid,
    input  wire logic                  i_out_ready,
    input  wire logic                  i_accepted,
    input  wire logic [CNT_W-1:0]      i_bin_count,
    input  wire logic [CNT_W-1:0]      i_peak_count,
    input  wire logic [CNT_W-1:0]      i_rebin_count,
    input  wire logic [CNT_W-1:0]      i_rebin_peak,
    // config channel
    input  wire logic                  i_cfg_valid,
    input  wire logic                  i_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    // status for the stimulus side
    output int                         o_failures,
    output int                         o_pending
);

    typedef struct packed {
        logic             accepted;
        logic [CNT_W-1:0] bin_count;
        logic [CNT_W-1:0] peak_count;
        logic [CNT_W-1:0] rebin_count;
        logic [CNT_W-1:0] rebin_peak;
    } t_photon_result;

    // mirrored images, peaks and registers
    logic [CNT_W-1:0] count_img [FULL_DEPTH];
    logic [CNT_W-1:0] rebin_img [REBIN_DEPTH];
    logic [CNT_W-1:0] full_peak;
    logic [CNT_W-1:0] coarse_peak;
    logic [LIM_W-1:0] x_lim;
    logic [LIM_W-1:0] y_lim;
    logic [FAC_W-1:0] factor;

    t_photon_result expected_counts [$];
    int fail_count   = 0;
    int queued_count = 0;

    assign o_failures = fail_count;
    assign o_pending  = queued_count;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    task automatic wipe_images();
        foreach (count_img[i]) count_img[i] = '0;
        foreach (rebin_img[i]) rebin_img[i] = '0;
        full_peak   = '0;
        coarse_peak = '0;
    endtask

    // one item: update the mirrored images and form its result
    task automatic count_photon(input logic func, input logic [COORD_W-1:0] x,
                                input logic [COORD_W-1:0] y, output t_photon_result r);
        int xl, yl, f, rx, ry, bx, by, idx, ridx;
        r = '0;
        if (func == FUNC_CLEAR) begin
            wipe_images();
        end else begin
            xl = (int'(x_lim) < X_SIZE) ? int'(x_lim) : X_SIZE;
            yl = (int'(y_lim) < Y_SIZE) ? int'(y_lim) : Y_SIZE;
            if (int'(x) < xl && int'(y) < yl) begin
                r.accepted = 1'b1;
                idx = int'(x) * Y_SIZE + int'(y);
                count_img[idx] = sat_inc(count_img[idx]);
                r.bin_count = count_img[idx];
                if (r.bin_count > full_peak) full_peak = r.bin_count;
                // factor zero means off, above the maximum it saturates
                f = int'(factor);
                if (f == 0) f = 1;
                if (f > MAX_FACTOR) f = MAX_FACTOR;
                if (f > 1) begin
                    rx = xl / f;
                    ry = yl / f;
                    bx = int'(x) / f;
                    by = int'(y) / f;
                    // bins past the floor-sized image are dropped
                    if (bx < rx && by < ry) begin
                        ridx = bx * ry + by;
                        rebin_img[ridx] = sat_inc(rebin_img[ridx]);
                        r.rebin_count = rebin_img[ridx];
                        if (r.rebin_count > coarse_peak) coarse_peak = r.rebin_count;
                    end
                end
            end
        end
        r.peak_count = full_peak;
        r.rebin_peak = coarse_peak;
    endtask

    task automatic check_field(input string name, input logic [CNT_W-1:0] want,
                               input logic [CNT_W-1:0] got);
        if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
                $display("mismatch in %s: expected %0d, got %0d", name, want, got);
        end
    endtask

    // sample all channels at the rising edge
    always @(posedge i_clk) begin : watch
        t_photon_result r;
        t_photon_result want;
        if (!i_rst_n) begin
            wipe_images();
            x_lim  = LIM_W'(X_SIZE);
            y_lim  = LIM_W'(Y_SIZE);
            factor = FAC_W'(1);
            expected_counts.delete();
        end else begin
            // register write transfer
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_X_LIMIT:      x_lim  = i_cfg_data[LIM_W-1:0];
                    REG_Y_LIMIT:      y_lim  = i_cfg_data[LIM_W-1:0];
                    REG_REBIN_FACTOR: factor = i_cfg_data[FAC_W-1:0];
                    default: ;
                endcase
            end
            // input transfer
            if (i_in_valid && i_in_ready) begin
                count_photon(i_func, i_x_coord, i_y_coord, r);
                expected_counts.push_back(r);
            end
            // result transfer
            if (i_out_valid && i_out_ready) begin
                if (expected_counts.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("result with no item waiting: accepted %0b bin %0d",
                                 i_accepted, i_bin_count);
                end else begin
                    want = expected_counts.pop_front();
                    check_field("accepted", CNT_W'(want.accepted), CNT_W'(i_accepted));
                    check_field("bin_count", want.bin_count, i_bin_count);
                    check_field("peak_count", want.peak_count, i_peak_count);
                    check_field("rebin_count", want.rebin_count, i_rebin_count);
                    check_field("rebin_peak", want.rebin_peak, i_rebin_peak);
                end
            end
        end
        queued_count = expected_counts.size();
    end

endmodule

### sim/testbench.sv
// top of the photon histogram testbench: clock, reset, stimulus and verdict
// depends on phr_pkg, photon_histogram_with_rebin and histogram_checker
`timescale 1ns / 1ps

module testbench;
    import phr_pkg::*;

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 210;
    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(3);

    logic                  i_clk;
    logic                  i_rst_n   = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_func   = FUNC_EVENT;
    logic [COORD_W-1:0]    in_x      = '0;
    logic [COORD_W-1:0]    in_y      = '0;
    logic                  out_ready = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    logic                  o_in_ready;
    logic                  o_out_valid;
    logic                  o_accepted;
    logic [CNT_W-1:0]      o_bin_count;
    logic [CNT_W-1:0]      o_peak_count;
    logic [CNT_W-1:0]      o_rebin_count;
    logic [CNT_W-1:0]      o_rebin_peak;
    logic                  o_cfg_ready;

    int failures;
    int pending;
    int idle_pct    = 0;
    int stall_left  = 0;
    int cycle_count = 0;

    photon_histogram_with_rebin uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (o_in_ready),
        .i_func       (in_func),
        .i_x_coord    (in_x),
        .i_y_coord    (in_y),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (out_ready),
        .o_accepted   (o_accepted),
        .o_bin_count  (o_bin_count),
        .o_peak_count (o_peak_count),
        .o_rebin_count(o_rebin_count),
        .o_rebin_peak (o_rebin_peak),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data)
    );

    histogram_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (o_in_ready),
        .i_func       (in_func),
        .i_x_coord    (in_x),
        .i_y_coord    (in_y),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (out_ready),
        .i_accepted   (o_accepted),
        .i_bin_count  (o_bin_count),
        .i_peak_count (o_peak_count),
        .i_rebin_count(o_rebin_count),
        .i_rebin_peak (o_rebin_peak),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_failures   (failures),
        .o_pending    (pending)
    );

    // 4 ns clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** photon_histogram_with_rebin: FAILED **");
            $finish;
        end
    end

    // result side back-pressure in bursts
    initial begin
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else if ($urandom_range(0, 99) < idle_pct / 3) begin
                stall_left = $urandom_range(0, 15);
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // present one item and hold it until its transfer; valid is left high
    task automatic send_item(input logic f, input logic [COORD_W-1:0] x,
                             input logic [COORD_W-1:0] y);
        int gap;
        @(negedge i_clk);
        if ($urandom_range(0, 99) < idle_pct) begin
            gap = $urandom_range(1, 16);
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_func  <= f;
        in_x     <= x;
        in_y     <= y;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // drop valid and wait for every result to come back
    task automatic settle();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] xl,
                             input logic [CFG_DATA_W-1:0] yl,
                             input logic [CFG_DATA_W-1:0] fd);
        settle();
        write_reg(REG_X_LIMIT, xl);
        write_reg(REG_Y_LIMIT, yl);
        write_reg(REG_REBIN_FACTOR, fd);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic int eff_limit(input int v);
        return (v > X_SIZE) ? X_SIZE : v;
    endfunction

    initial begin : stimulus
        int xl, yl, fd, exl, eyl, kind, p, i;
        logic [COORD_W-1:0] hot_x [4];
        logic [COORD_W-1:0] hot_y [4];
        logic [CFG_DATA_W-1:0] fdata;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // defaults: rebinning off, corners, repeat hit, clear with junk coordinates
        send_item(FUNC_EVENT, 8'd0, 8'd0);
        send_item(FUNC_EVENT, 8'd255, 8'd255);
        send_item(FUNC_EVENT, 8'd0, 8'd0);
        send_item(FUNC_CLEAR, 8'hA5, 8'h5A);

        // x limit above the image size, factor 2
        configure(9'd511, 9'd256, 9'd2);
        send_item(FUNC_EVENT, 8'd255, 8'd0);
        send_item(FUNC_EVENT, 8'd0, 8'd255);
        send_item(FUNC_EVENT, 8'd1, 8'd1);
        send_item(FUNC_EVENT, 8'd0, 8'd0);
        send_item(FUNC_EVENT, 8'd1, 8'd0);

        // odd limits: bin past the floor-sized image, events past the limits
        configure(9'd5, 9'd7, 9'd2);
        send_item(FUNC_EVENT, 8'd4, 8'd0);
        send_item(FUNC_EVENT, 8'd3, 8'd5);
        send_item(FUNC_EVENT, 8'd5, 8'd0);
        send_item(FUNC_EVENT, 8'd0, 8'd7);

        // zero limit accepts nothing, factor zero
        configure(9'd0, 9'd256, 9'd0);
        send_item(FUNC_EVENT, 8'd0, 8'd0);

        // single pixel window
        configure(9'd1, 9'd1, 9'd1);
        send_item(FUNC_EVENT, 8'd0, 8'd0);
        send_item(FUNC_EVENT, 8'd0, 8'd1);

        // factor above the maximum, upper data bits set
        configure(9'd256, 9'd256, 9'h1F1);
        send_item(FUNC_EVENT, 8'd255, 8'd255);
        send_item(FUNC_EVENT, 8'd17, 8'd33);

        // write to the unused index has no effect, factor at its top code
        settle();
        write_reg(REG_UNUSED, 9'h1AA);
        write_reg(REG_REBIN_FACTOR, 9'h01F);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
        send_item(FUNC_EVENT, 8'd240, 8'd16);
        send_item(FUNC_EVENT, 8'd255, 8'd255);

        // random phases, each with its own geometry
        for (p = 0; p < PHASES; p++) begin
            case (p)
                0: begin xl = 256; yl = 256; fd = 2;  end
                1: begin xl = 256; yl = 256; fd = 16; end
                2: begin xl = 3;   yl = 256; fd = 2;  end
                3: begin xl = 511; yl = 300; fd = 31; end
                default: begin
                    xl = ($urandom_range(0, 3) == 0) ? $urandom_range(257, 511)
                                                     : $urandom_range(1, 256);
                    yl = ($urandom_range(0, 3) == 0) ? $urandom_range(257, 511)
                                                     : $urandom_range(1, 256);
                    fd = $urandom_range(0, 31);
                end
            endcase
            fdata = CFG_DATA_W'($urandom);
            fdata[FAC_W-1:0] = FAC_W'(fd);
            configure(CFG_DATA_W'(xl), CFG_DATA_W'(yl), fdata);

            // idling varies per phase, none at the end
            case ($urandom_range(0, 2))
                0: idle_pct = 0;
                1: idle_pct = 10;
                default: idle_pct = 30;
            endcase
            if (p == PHASES - 1) idle_pct = 0;

            if (p == 0 || p == 3 || p == 5 || p == 7)
                send_item(FUNC_CLEAR, COORD_W'($urandom), COORD_W'($urandom));

            exl = eff_limit(xl);
            eyl = eff_limit(yl);
            for (i = 0; i < 4; i++) begin
                hot_x[i] = COORD_W'($urandom_range(0, exl - 1));
                hot_y[i] = COORD_W'($urandom_range(0, eyl - 1));
            end

            // hot pixels build up counts, uniform hits spread them, the rest is noise
            for (i = 0; i < PHASE_ITEMS; i++) begin
                kind = $urandom_range(0, 9);
                if (kind < 4) begin
                    kind = $urandom_range(0, 3);
                    send_item(FUNC_EVENT, hot_x[kind], hot_y[kind]);
                end else if (kind < 8) begin
                    send_item(FUNC_EVENT, COORD_W'($urandom_range(0, exl - 1)),
                              COORD_W'($urandom_range(0, eyl - 1)));
                end else begin
                    send_item(FUNC_EVENT, COORD_W'($urandom), COORD_W'($urandom));
                end
            end
        end

        // drain and verdict
        settle();
        repeat (32) @(posedge i_clk);
        if (failures == 0 && pending == 0) begin
            $display("** photon_histogram_with_rebin: PASSED **");
        end else begin
            $display("** photon_histogram_with_rebin: FAILED **");
        end
        $finish;
    end

endmodule
